FILE: sv/frs_pkg.sv
// Shared constants and types for the frame rate statistics unit.
package frs_pkg;

    localparam int CNT_W          = 48;
    localparam int TIME_W         = 64;
    localparam int WIN_LEN_W      = 40;
    localparam int WCOUNT_W       = 32;
    localparam int RATE_W         = 24;
    localparam int RATE_FRAC_BITS = 8;
    localparam int NS_W           = 30;
    localparam int PROD_W         = WCOUNT_W + NS_W;
    localparam int NUM_W          = PROD_W + RATE_FRAC_BITS;
    localparam int HI_W           = NUM_W - RATE_W;
    localparam int STEP_W         = $clog2(RATE_W);

    localparam logic [NS_W-1:0]      NS_PER_S       = NS_W'(1000000000);
    localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET  = WIN_LEN_W'(1000000000);
    localparam logic [RATE_W-1:0]    RATE_MAX       = {RATE_W{1'b1}};
    localparam logic [WCOUNT_W-1:0]  WCOUNT_MAX     = {WCOUNT_W{1'b1}};

    typedef struct packed {
        logic                start;
        logic [WCOUNT_W-1:0] cnt;
        logic [TIME_W-1:0]   elapsed;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] rate;
    } t_div_rsp;

endpackage

FILE: sv/frs_if.sv
// Handshake channels for frame events and statistics results.
interface frs_evt_if;
    logic                        valid;
    logic                        ready;
    logic                        frame_presented;
    logic                        frame_dropped;
    logic                        frame_duplicated;
    logic [frs_pkg::TIME_W-1:0]  time_ns;

    modport source (output valid, frame_presented, frame_dropped, frame_duplicated, time_ns,
                    input ready);
    modport sink (input valid, frame_presented, frame_dropped, frame_duplicated, time_ns,
                  output ready);
endinterface

interface frs_stat_if;
    logic                        valid;
    logic                        ready;
    logic [frs_pkg::CNT_W-1:0]   presented_total;
    logic [frs_pkg::CNT_W-1:0]   dropped_total;
    logic [frs_pkg::CNT_W-1:0]   duplicated_total;
    logic [frs_pkg::RATE_W-1:0]  smoothed_rate;

    modport source (output valid, presented_total, dropped_total, duplicated_total,
                    smoothed_rate, input ready);
    modport sink (input valid, presented_total, dropped_total, duplicated_total,
                  smoothed_rate, output ready);
endinterface

FILE: sv/frame_rate_statistics_unit.sv
// Top level of the frame rate statistics unit: counters, window and smoothing.
//
// Channel   Dir  Payload
// i_evt     in   frame_presented, frame_dropped, frame_duplicated, time_ns
// o_stat    out  presented_total, dropped_total, duplicated_total, smoothed_rate
// i_cfg_*   in   window_length_ns (write only)
//
// An event that does not close a window passes via S_PUSH to the result register.
// An event that closes a window runs one multiply, one overflow check
// and 24 restoring division steps in the shared subtractor, then the blend.
// When the new rate saturates the division steps are skipped.
// The input is ready only while no event is in progress; the result register
// holds its transaction until taken. Reset is synchronous, output data excepted.
module frame_rate_statistics_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [frs_pkg::WIN_LEN_W-1:0]     i_cfg_wr_data,
    frs_evt_if.sink                           i_evt,
    frs_stat_if.source                        o_stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [1:0]                      r_state;
    logic [frs_pkg::WIN_LEN_W-1:0]   r_win_len;
    logic [frs_pkg::CNT_W-1:0]       r_pres_cnt;
    logic [frs_pkg::CNT_W-1:0]       r_drop_cnt;
    logic [frs_pkg::CNT_W-1:0]       r_dup_cnt;
    logic [frs_pkg::TIME_W-1:0]      r_wstart;
    logic [frs_pkg::WCOUNT_W-1:0]    r_wcount;
    logic [frs_pkg::RATE_W-1:0]      r_rate;
    logic                            r_out_valid;
    logic [frs_pkg::CNT_W-1:0]       r_out_pres;
    logic [frs_pkg::CNT_W-1:0]       r_out_drop;
    logic [frs_pkg::CNT_W-1:0]       r_out_dup;
    logic [frs_pkg::RATE_W-1:0]      r_out_rate;

    logic                            w_accept;
    logic                            w_load;
    logic [frs_pkg::WCOUNT_W-1:0]    w_wcount_inc;
    logic [frs_pkg::TIME_W-1:0]      w_elapsed;
    logic                            w_close;
    logic signed [frs_pkg::RATE_W:0] w_delta;
    logic [frs_pkg::RATE_W:0]        w_blend;
    frs_pkg::t_div_req               w_req;
    frs_pkg::t_div_rsp               w_rsp;

    assign i_evt.ready  = (r_state == S_IDLE);
    assign w_accept     = i_evt.valid && i_evt.ready;
    assign w_load       = (r_state == S_PUSH) && (!r_out_valid || o_stat.ready);

    assign w_wcount_inc = (r_wcount == frs_pkg::WCOUNT_MAX) ? r_wcount : r_wcount + 1'b1;
    assign w_elapsed    = i_evt.time_ns - r_wstart;
    assign w_close      = i_evt.frame_presented && (r_wstart != '0)
                          && (w_elapsed >= {{(frs_pkg::TIME_W - frs_pkg::WIN_LEN_W){1'b0}},
                                            r_win_len});

    assign w_req.start   = w_accept && w_close;
    assign w_req.cnt     = w_wcount_inc;
    assign w_req.elapsed = w_elapsed;

    // Blend moves the estimate one eighth of the way, rounding toward minus infinity.
    assign w_delta = $signed({1'b0, w_rsp.rate}) - $signed({1'b0, r_rate});
    assign w_blend = {1'b0, r_rate} + $unsigned(w_delta >>> 3);

    frs_rate_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_win_len  <= frs_pkg::WIN_LEN_RESET;
            r_pres_cnt <= '0;
            r_drop_cnt <= '0;
            r_dup_cnt  <= '0;
            r_wstart   <= '0;
            r_wcount   <= '0;
            r_rate     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_win_len <= i_cfg_wr_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_evt.frame_presented) begin
                            r_pres_cnt <= r_pres_cnt + 1'b1;
                            if (r_wstart == '0) begin
                                r_wstart <= i_evt.time_ns;
                                r_wcount <= w_wcount_inc;
                            end else if (w_close) begin
                                r_wstart <= i_evt.time_ns;
                                r_wcount <= '0;
                            end else begin
                                r_wcount <= w_wcount_inc;
                            end
                        end
                        if (i_evt.frame_dropped) begin
                            r_drop_cnt <= r_drop_cnt + 1'b1;
                        end
                        if (i_evt.frame_duplicated) begin
                            r_dup_cnt <= r_dup_cnt + 1'b1;
                        end
                        r_state <= w_close ? S_DIV : S_PUSH;
                    end
                end
                S_DIV: begin
                    if (w_rsp.done) begin
                        if (r_rate == '0) begin
                            r_rate <= w_rsp.rate;
                        end else begin
                            r_rate <= w_blend[frs_pkg::RATE_W-1:0];
                        end
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_stat.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_pres <= r_pres_cnt;
            r_out_drop <= r_drop_cnt;
            r_out_dup  <= r_dup_cnt;
            r_out_rate <= r_rate;
        end
    end

    assign o_stat.valid            = r_out_valid;
    assign o_stat.presented_total  = r_out_pres;
    assign o_stat.dropped_total    = r_out_drop;
    assign o_stat.duplicated_total = r_out_dup;
    assign o_stat.smoothed_rate    = r_out_rate;

endmodule

FILE: sv/frs_rate_div.sv
// Rate measurement: count times 1e9 in Q16.8, divided by elapsed time bit by bit.
module frs_rate_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  frs_pkg::t_div_req i_req,
    output frs_pkg::t_div_rsp o_rsp
);

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_MUL  = 3'd1;
    localparam logic [2:0] D_SAT  = 3'd2;
    localparam logic [2:0] D_DIV  = 3'd3;
    localparam logic [2:0] D_DONE = 3'd4;

    logic [2:0]                        r_state;
    logic [frs_pkg::WCOUNT_W-1:0]      r_cnt;
    logic [frs_pkg::TIME_W-1:0]        r_den;
    logic [frs_pkg::HI_W-1:0]          r_hi;
    logic [frs_pkg::RATE_W-1:0]        r_low;
    logic [frs_pkg::TIME_W-1:0]        r_rem;
    logic [frs_pkg::STEP_W-1:0]        r_step;
    logic [frs_pkg::PROD_W-1:0]        w_prod;
    logic [frs_pkg::TIME_W:0]          w_opa;
    logic [frs_pkg::TIME_W:0]          w_diff;
    logic                              w_fits;

    assign w_prod = frs_pkg::PROD_W'(r_cnt) * frs_pkg::PROD_W'(frs_pkg::NS_PER_S);

    // One subtractor serves both the saturation check and every division step.
    always_comb begin
        if (r_state == D_SAT) begin
            w_opa = {1'b0, {(frs_pkg::TIME_W - frs_pkg::HI_W){1'b0}}, r_hi};
        end else begin
            w_opa = {r_rem, r_low[frs_pkg::RATE_W-1]};
        end
        w_diff = w_opa - {1'b0, r_den};
        w_fits = !w_diff[frs_pkg::TIME_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_cnt   <= i_req.cnt;
                        r_den   <= i_req.elapsed;
                        r_state <= D_MUL;
                    end
                end
                D_MUL: begin
                    {r_hi, r_low} <= {w_prod, {frs_pkg::RATE_FRAC_BITS{1'b0}}};
                    r_state       <= D_SAT;
                end
                D_SAT: begin
                    // The quotient overflows exactly when the upper numerator part
                    // already reaches the divisor; that also covers a zero divisor.
                    if (w_fits) begin
                        r_low   <= frs_pkg::RATE_MAX;
                        r_state <= D_DONE;
                    end else begin
                        r_rem   <= {{(frs_pkg::TIME_W - frs_pkg::HI_W){1'b0}}, r_hi};
                        r_step  <= frs_pkg::STEP_W'(frs_pkg::RATE_W - 1);
                        r_state <= D_DIV;
                    end
                end
                D_DIV: begin
                    if (w_fits) begin
                        r_rem <= w_diff[frs_pkg::TIME_W-1:0];
                    end else begin
                        r_rem <= w_opa[frs_pkg::TIME_W-1:0];
                    end
                    r_low <= {r_low[frs_pkg::RATE_W-2:0], w_fits};
                    if (r_step == '0) begin
                        r_state <= D_DONE;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                D_DONE: begin
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = (r_state == D_DONE);
    assign o_rsp.rate = r_low;

endmodule

FILE: tb/tb_frame_rate_statistics_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the frame rate statistics unit: directed table, then random phases.
module tb_frame_rate_statistics_unit;

    localparam int CYCLE_LIMIT   = 500_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 138;
    localparam int STEADY_PHASE  = 3;
    localparam int MAX_GAP       = 16;
    localparam int IDLE_PCT      = 24;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [frs_pkg::CNT_W-1:0]  presented_total;
        logic [frs_pkg::CNT_W-1:0]  dropped_total;
        logic [frs_pkg::CNT_W-1:0]  duplicated_total;
        logic [frs_pkg::RATE_W-1:0] smoothed_rate;
    } t_stat_rec;

    typedef enum logic {ROW_EVENT, ROW_WINDOW} t_row_kind;

    // One line of the directed table; flags are {presented, dropped, duplicated}.
    typedef struct {
        t_row_kind                  kind;
        logic [2:0]                 flags;
        logic [frs_pkg::TIME_W-1:0] value;
        bit                         known;
        t_stat_rec                  want;
    } t_stim_row;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [frs_pkg::WIN_LEN_W-1:0] cfg_wr_data;
    bit                            steady_run = 1'b0;
    int                            mismatch_count = 0;

    frs_evt_if  evt_ch ();
    frs_stat_if stat_ch ();

    frame_rate_statistics_unit uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_evt        (evt_ch),
        .o_stat       (stat_ch)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predictor state, starting from the reset values.
    logic [frs_pkg::WIN_LEN_W-1:0] window_len_ns  = frs_pkg::WIN_LEN_RESET;
    logic [frs_pkg::CNT_W-1:0]     presented_cnt  = '0;
    logic [frs_pkg::CNT_W-1:0]     dropped_cnt    = '0;
    logic [frs_pkg::CNT_W-1:0]     duplicated_cnt = '0;
    logic [frs_pkg::TIME_W-1:0]    win_start_ns   = '0;
    logic [frs_pkg::WCOUNT_W-1:0]  win_frames     = '0;
    logic [frs_pkg::RATE_W-1:0]    rate_q8        = '0;

    t_stat_rec pending_stats[$];
    t_stim_row stim_rows[$];

    logic [frs_pkg::WIN_LEN_W-1:0] phase_windows [NUM_PHASES] = '{
        40'd1_000_000_000, 40'd50_000, 40'd0, 40'd2_000_000,
        40'hFF_FFFF_FFFF, 40'd1, 40'd250_000_000, 40'd30_000_000
    };

    // Frames per second in Q16.8 over one window, saturating at the top of the range.
    function automatic logic [frs_pkg::RATE_W-1:0] window_rate_q8(
            input logic [frs_pkg::WCOUNT_W-1:0] frames,
            input logic [frs_pkg::TIME_W-1:0] elapsed);
        logic [127:0] scaled;
        logic [127:0] quot;
        if (elapsed == '0) begin
            return frs_pkg::RATE_MAX;
        end
        scaled = (128'(frames) * 128'(frs_pkg::NS_PER_S)) << frs_pkg::RATE_FRAC_BITS;
        quot   = scaled / 128'(elapsed);
        return (quot > 128'(frs_pkg::RATE_MAX)) ? frs_pkg::RATE_MAX
                                                : quot[frs_pkg::RATE_W-1:0];
    endfunction

    function automatic t_stat_rec advance_frame_stats(input logic pres, input logic drop,
                                                      input logic dup,
                                                      input logic [frs_pkg::TIME_W-1:0] now);
        logic [frs_pkg::TIME_W-1:0] elapsed;
        logic [frs_pkg::RATE_W-1:0] fresh;
        logic [frs_pkg::RATE_W:0]   fall;
        if (pres) begin
            presented_cnt = presented_cnt + 1'b1;
            if (win_frames != frs_pkg::WCOUNT_MAX) begin
                win_frames = win_frames + 1'b1;
            end
            if (win_start_ns == '0) begin
                win_start_ns = now;
            end else begin
                elapsed = now - win_start_ns;
                if (elapsed >= frs_pkg::TIME_W'(window_len_ns)) begin
                    fresh = window_rate_q8(win_frames, elapsed);
                    if (rate_q8 == '0) begin
                        rate_q8 = fresh;
                    end else if (fresh >= rate_q8) begin
                        rate_q8 = rate_q8 + ((fresh - rate_q8) >> 3);
                    end else begin
                        // A falling estimate moves down by the rounded-up eighth.
                        fall    = {1'b0, rate_q8} - {1'b0, fresh}
                                  + (frs_pkg::RATE_W+1)'(7);
                        rate_q8 = rate_q8 - frs_pkg::RATE_W'(fall >> 3);
                    end
                    win_start_ns = now;
                    win_frames   = '0;
                end
            end
        end
        if (drop) begin
            dropped_cnt = dropped_cnt + 1'b1;
        end
        if (dup) begin
            duplicated_cnt = duplicated_cnt + 1'b1;
        end
        return {presented_cnt, dropped_cnt, duplicated_cnt, rate_q8};
    endfunction

    task automatic add_row(input t_row_kind kind, input logic [2:0] flags,
                           input logic [frs_pkg::TIME_W-1:0] value, input bit known,
                           input t_stat_rec want);
        t_stim_row row;
        row.kind  = kind;
        row.flags = flags;
        row.value = value;
        row.known = known;
        row.want  = want;
        stim_rows.push_back(row);
    endtask

    // Offers one event, waits for the transaction and records what it must produce.
    task automatic send_event(input logic [2:0] flags, input logic [frs_pkg::TIME_W-1:0] now,
                              input bit known, input t_stat_rec want);
        int        gap;
        t_stat_rec predicted;
        gap = 0;
        while (!steady_run && gap < MAX_GAP && $urandom_range(99) < IDLE_PCT) begin
            gap++;
        end
        if (gap > 0) begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_ch.valid            <= 1'b1;
        evt_ch.frame_presented  <= flags[2];
        evt_ch.frame_dropped    <= flags[1];
        evt_ch.frame_duplicated <= flags[0];
        evt_ch.time_ns          <= now;
        do @(posedge clk); while (evt_ch.ready !== 1'b1);
        predicted = advance_frame_stats(flags[2], flags[1], flags[0], now);
        pending_stats.push_back(known ? want : predicted);
    endtask

    // The window length only changes once every outstanding transaction has come back.
    task automatic write_window(input logic [frs_pkg::WIN_LEN_W-1:0] length_ns);
        evt_ch.valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= length_ns;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        window_len_ns = length_ns;
    endtask

    task automatic note_mismatch(input string what, input t_stat_rec want,
                                 input t_stat_rec seen);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t %s: expected pres=%0d drop=%0d dup=%0d rate=%h", $realtime, what,
                     want.presented_total, want.dropped_total, want.duplicated_total,
                     want.smoothed_rate);
            $display("%0t %s: actual   pres=%0d drop=%0d dup=%0d rate=%h", $realtime, what,
                     seen.presented_total, seen.dropped_total, seen.duplicated_total,
                     seen.smoothed_rate);
        end
    endtask

    always @(posedge clk) begin : stat_monitor
        t_stat_rec seen;
        t_stat_rec want;
        if (rst_n === 1'b1 && stat_ch.valid === 1'b1 && stat_ch.ready === 1'b1) begin
            seen = {stat_ch.presented_total, stat_ch.dropped_total,
                    stat_ch.duplicated_total, stat_ch.smoothed_rate};
            if (pending_stats.size() == 0) begin
                note_mismatch("unexpected transaction", '0, seen);
            end else begin
                want = pending_stats.pop_front();
                if (seen.presented_total !== want.presented_total
                    || seen.dropped_total !== want.dropped_total
                    || seen.duplicated_total !== want.duplicated_total
                    || seen.smoothed_rate !== want.smoothed_rate) begin
                    note_mismatch("statistics mismatch", want, seen);
                end
            end
        end
        stat_ch.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
            @(posedge clk);
        end
        $display("[frame_rate_statistics_unit] ERROR");
        $finish;
    end

    initial begin
        int                            phase;
        int                            n;
        int                            roll;
        logic [2:0]                    flags;
        logic [frs_pkg::TIME_W-1:0]    now_ns;
        logic [frs_pkg::TIME_W-1:0]    span;
        logic [frs_pkg::WIN_LEN_W-1:0] win;

        rst_n                   <= 1'b0;
        cfg_wr_en               <= 1'b0;
        cfg_wr_data             <= '0;
        evt_ch.valid            <= 1'b0;
        evt_ch.frame_presented  <= 1'b0;
        evt_ch.frame_dropped    <= 1'b0;
        evt_ch.frame_duplicated <= 1'b0;
        evt_ch.time_ns          <= '0;

        // Directed part runs on the reset window length of one second first.
        add_row(ROW_EVENT, 3'b000, 64'd5, 1'b1, {48'd0, 48'd0, 48'd0, 24'd0});
        // A frame at time zero leaves the window closed.
        add_row(ROW_EVENT, 3'b100, 64'd0, 1'b1, {48'd1, 48'd0, 48'd0, 24'd0});
        add_row(ROW_EVENT, 3'b100, 64'd1000, 1'b1, {48'd2, 48'd0, 48'd0, 24'd0});
        add_row(ROW_EVENT, 3'b011, 64'd2000, 1'b1, {48'd2, 48'd1, 48'd1, 24'd0});
        // Three frames over 256 s load an estimate of exactly 3/256 fps.
        add_row(ROW_EVENT, 3'b100, 64'd256_000_001_000, 1'b1, {48'd3, 48'd1, 48'd1, 24'd3});
        // Time running backwards closes windows with a zero rate until the estimate is zero.
        add_row(ROW_EVENT, 3'b100, 64'd1000, 1'b0, '0);
        add_row(ROW_EVENT, 3'b100, 64'd500, 1'b0, '0);
        add_row(ROW_EVENT, 3'b100, 64'd100, 1'b0, '0);
        add_row(ROW_EVENT, 3'b100, 64'd1_000_000_100, 1'b0, '0);
        add_row(ROW_EVENT, 3'b100, 64'd1_000_000_100, 1'b0, '0);
        add_row(ROW_EVENT, 3'b111, 64'd3_000_000_100, 1'b0, '0);
        add_row(ROW_EVENT, 3'b100, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0);
        add_row(ROW_EVENT, 3'b100, 64'hFFFF_FFFF_0000_0000, 1'b0, '0);
        add_row(ROW_EVENT, 3'b100, 64'd0, 1'b0, '0);
        add_row(ROW_EVENT, 3'b100, 64'd7000, 1'b0, '0);
        add_row(ROW_WINDOW, 3'b000, 64'd0, 1'b0, '0);
        add_row(ROW_EVENT, 3'b100, 64'd7000, 1'b0, '0);
        add_row(ROW_EVENT, 3'b100, 64'd7001, 1'b0, '0);
        add_row(ROW_EVENT, 3'b010, 64'd0, 1'b0, '0);
        add_row(ROW_EVENT, 3'b001, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0);
        add_row(ROW_WINDOW, 3'b000, 64'hFF_FFFF_FFFF, 1'b0, '0);
        add_row(ROW_EVENT, 3'b100, 64'd1_000_000_007_001, 1'b0, '0);
        add_row(ROW_EVENT, 3'b101, 64'd1_099_511_634_776, 1'b0, '0);
        add_row(ROW_WINDOW, 3'b000, 64'd1, 1'b0, '0);
        add_row(ROW_EVENT, 3'b100, 64'd1_099_511_634_777, 1'b0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_WINDOW) begin
                write_window(stim_rows[i].value[frs_pkg::WIN_LEN_W-1:0]);
            end else begin
                send_event(stim_rows[i].flags, stim_rows[i].value, stim_rows[i].known,
                           stim_rows[i].want);
            end
        end

        now_ns = 64'd1_099_511_634_777;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            win = (phase == NUM_PHASES - 1) ? frs_pkg::WIN_LEN_W'({$urandom, $urandom})
                                            : phase_windows[phase];
            write_window(win);
            steady_run <= (phase == STEADY_PHASE);
            // Steps of up to a quarter window give a few frames per window.
            span = (win < 40'd16) ? 64'd100_000 : (frs_pkg::TIME_W'(win) >> 2);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(99);
                if (roll < 82) begin
                    now_ns   = now_ns + ({$urandom, $urandom} % span);
                    flags[2] = ($urandom_range(99) < 75);
                    flags[1] = ($urandom_range(3) == 0);
                    flags[0] = ($urandom_range(3) == 0);
                end else if (roll < 92) begin
                    now_ns = {$urandom, $urandom};
                    flags  = 3'($urandom_range(7));
                end else if (roll < 95) begin
                    now_ns = '0;
                    flags  = 3'b100;
                end else if (roll < 98) begin
                    now_ns = now_ns - frs_pkg::TIME_W'($urandom_range(1, 1_000_000));
                    flags  = 3'b100;
                end else begin
                    now_ns = '1;
                    flags  = 3'b100;
                end
                send_event(flags, now_ns, 1'b0, '0);
            end
        end

        evt_ch.valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("[frame_rate_statistics_unit] OK");
        end else begin
            $display("[frame_rate_statistics_unit] ERROR");
        end
        $finish;
    end

endmodule
